@@ hdl/ffha_pkg.sv @@
// shared types and constants for the first-fit hole allocator
package ffha_pkg;

    localparam int DATA_W   = 16;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int LEFT_W   = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD  = 2'd0,
        FN_ALLOC = 2'd1,
        FN_CLEAR = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE  = 3'd0,
        STS_ALLOC = 3'd1,
        STS_NOFIT = 3'd2,
        STS_FULL  = 3'd3,
        STS_HALT  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

@@ hdl/ffha_alu.sv @@
// shared adder/subtractor used for the fit compare and the base move-up
module ffha_alu #(
    parameter int W = 16
) (
    input  ffha_pkg::alu_op_t op,
    input  logic [W-1:0]      a,
    input  logic [W-1:0]      b,
    output logic [W-1:0]      sum,
    output logic              carry
);

    logic [W-1:0] b_eff;
    logic         cin;
    logic [W:0]   full;

    always_comb
    begin
        b_eff = (op == ffha_pkg::ALU_SUB) ? ~b : b;
        cin   = (op == ffha_pkg::ALU_SUB);
    end

    // for subtract, carry high means a >= b
    assign full  = {1'b0, a} + {1'b0, b_eff} + (W+1)'(cin);
    assign sum   = full[W-1:0];
    assign carry = full[W];

endmodule

@@ hdl/first_fit_hole_allocator_top.sv @@
// first-fit hole allocator: hole table, scan sequencer and result register
// load, clear and unused codes: result strobe in the cycle after the transaction
// allocate hitting entry k: scan entries 0 to k, write back in S_UPDATE, then strobe; busy meanwhile
// allocate with no fit: strobe after every entry is scanned; halted allocate: strobe in the cycle after
// the scan reads one table entry per cycle through a single registered read port
// reset clears the valid bits, fill pointer, hole count and halt flag; the receiver cannot stall
module first_fit_hole_allocator_top #(
    parameter int MAX_HOLES = 16,
    parameter int ADDR_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ffha_pkg::FUNC_W-1:0]       func,
    input  logic [ffha_pkg::DATA_W-1:0]       hole_base,
    input  logic [ffha_pkg::DATA_W-1:0]       length,
    output logic                              done,
    output logic [ffha_pkg::STATUS_W-1:0]     status,
    output logic [ffha_pkg::DATA_W-1:0]       alloc_base,
    output logic [ffha_pkg::LEFT_W-1:0]       holes_left
);

    localparam int IW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int CW = $clog2(MAX_HOLES + 1);
    localparam int AW = (ADDR_BITS > ffha_pkg::DATA_W) ? ADDR_BITS : ffha_pkg::DATA_W;
    localparam int DW = ffha_pkg::DATA_W;

    // hole table storage
    logic [ADDR_BITS-1:0] start_mem [MAX_HOLES];
    logic [DW-1:0]        len_mem   [MAX_HOLES];

    ffha_pkg::state_t     state_reg, state_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [MAX_HOLES-1:0] valid_reg, valid_next;
    logic                 halted_reg, halted_next;
    logic [DW-1:0]        len_reg, len_next;
    logic [ADDR_BITS-1:0] granted_reg, granted_next;
    logic [DW-1:0]        rem_reg, rem_next;

    logic                 done_reg, done_next;
    ffha_pkg::status_t    status_reg, status_next;
    logic [DW-1:0]        base_reg, base_next;
    logic [CW-1:0]        left_reg, left_next;

    logic [ADDR_BITS-1:0] rd_start_reg;
    logic [DW-1:0]        rd_len_reg;
    logic [IW-1:0]        rd_addr;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [ADDR_BITS-1:0] wr_start;
    logic [DW-1:0]        wr_len;

    ffha_pkg::alu_op_t    alu_op;
    logic [AW-1:0]        alu_a;
    logic [AW-1:0]        alu_b;
    logic [AW-1:0]        alu_sum;
    logic                 alu_carry;

    ffha_alu #(
        .W (AW)
    ) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    always_comb
    begin
        if (state_reg == ffha_pkg::S_SCAN)
        begin
            alu_op = ffha_pkg::ALU_SUB;
            alu_a  = AW'(rd_len_reg);
        end
        else
        begin
            alu_op = ffha_pkg::ALU_ADD;
            alu_a  = AW'(granted_reg);
        end
        alu_b = AW'(len_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_mem[wr_addr] <= wr_start;
            len_mem[wr_addr]   <= wr_len;
        end
        rd_start_reg <= start_mem[rd_addr];
        rd_len_reg   <= len_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ffha_pkg::S_IDLE;
            fill_reg   <= '0;
            count_reg  <= '0;
            valid_reg  <= '0;
            halted_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            count_reg  <= count_next;
            valid_reg  <= valid_next;
            halted_reg <= halted_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        len_reg     <= len_next;
        granted_reg <= granted_next;
        rem_reg     <= rem_next;
        status_reg  <= status_next;
        base_reg    <= base_next;
        left_reg    <= left_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        fill_next    = fill_reg;
        count_next   = count_reg;
        valid_next   = valid_reg;
        halted_next  = halted_reg;
        len_next     = len_reg;
        granted_next = granted_reg;
        rem_next     = rem_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        base_next    = base_reg;
        left_next    = left_reg;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_start     = ADDR_BITS'(hole_base);
        wr_len       = length;

        unique case (state_reg)
            ffha_pkg::S_IDLE:
            begin
                if (start)
                begin
                    done_next   = 1'b1;
                    status_next = ffha_pkg::STS_DONE;
                    base_next   = '0;
                    left_next   = count_reg;
                    len_next    = length;
                    unique case (ffha_pkg::func_t'(func))
                        ffha_pkg::FN_LOAD:
                        begin
                            if (fill_reg == CW'(MAX_HOLES))
                            begin
                                status_next = ffha_pkg::STS_FULL;
                            end
                            else
                            begin
                                wr_en                       = 1'b1;
                                wr_addr                     = fill_reg[IW-1:0];
                                valid_next[fill_reg[IW-1:0]] = 1'b1;
                                fill_next                   = fill_reg + 1'b1;
                                count_next                  = count_reg + 1'b1;
                                left_next                   = count_reg + 1'b1;
                            end
                        end
                        ffha_pkg::FN_ALLOC:
                        begin
                            if (halted_reg)
                            begin
                                status_next = ffha_pkg::STS_HALT;
                            end
                            else
                            begin
                                // entry zero is read now, checked next cycle
                                done_next  = 1'b0;
                                idx_next   = '0;
                                state_next = ffha_pkg::S_SCAN;
                            end
                        end
                        ffha_pkg::FN_CLEAR:
                        begin
                            valid_next  = '0;
                            fill_next   = '0;
                            count_next  = '0;
                            halted_next = 1'b0;
                            left_next   = '0;
                        end
                        default:
                        begin
                            status_next = ffha_pkg::STS_DONE;
                        end
                    endcase
                end
            end
            ffha_pkg::S_SCAN:
            begin
                rd_addr = (idx_reg == IW'(MAX_HOLES - 1)) ? '0 : idx_reg + 1'b1;
                if (valid_reg[idx_reg] && alu_carry)
                begin
                    granted_next = rd_start_reg;
                    rem_next     = alu_sum[DW-1:0];
                    state_next   = ffha_pkg::S_UPDATE;
                end
                else if (idx_reg == IW'(MAX_HOLES - 1))
                begin
                    halted_next = 1'b1;
                    done_next   = 1'b1;
                    status_next = ffha_pkg::STS_NOFIT;
                    base_next   = '0;
                    left_next   = count_reg;
                    state_next  = ffha_pkg::S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ffha_pkg::S_UPDATE:
            begin
                wr_en       = 1'b1;
                wr_addr     = idx_reg;
                wr_start    = alu_sum[ADDR_BITS-1:0];
                wr_len      = rem_reg;
                done_next   = 1'b1;
                status_next = ffha_pkg::STS_ALLOC;
                base_next   = DW'(granted_reg);
                left_next   = count_reg;
                // hole used up
                if (rem_reg == '0)
                begin
                    valid_next[idx_reg] = 1'b0;
                    count_next          = count_reg - 1'b1;
                    left_next           = count_reg - 1'b1;
                end
                state_next = ffha_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ffha_pkg::S_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != ffha_pkg::S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign alloc_base = base_reg;
    assign holes_left = ffha_pkg::LEFT_W'(left_reg);

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CW'($countones(valid_reg)))
        else $error("hole count out of step with valid bits");

    a_count_within_fill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fill_reg)
        else $error("hole count exceeds fill pointer");

    a_update_grants: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ffha_pkg::S_UPDATE |=> done && status == ffha_pkg::STS_ALLOC)
        else $error("update did not produce an allocated result");

    a_halted_refuses: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ffha_pkg::S_IDLE && start && halted_reg &&
        func == ffha_pkg::FN_ALLOC |=> done && status == ffha_pkg::STS_HALT)
        else $error("allocate while halted was not refused");

    a_base_zero_unless_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ffha_pkg::STS_ALLOC |-> alloc_base == '0)
        else $error("nonzero base on a non-allocate result");

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench for the first-fit hole allocator with its own table predictor
module tb_top;

    localparam int          HOLES    = 16;
    localparam int          FW       = ffha_pkg::FUNC_W;
    localparam int          DW       = ffha_pkg::DATA_W;
    localparam int          SW       = ffha_pkg::STATUS_W;
    localparam int          LW       = ffha_pkg::LEFT_W;
    localparam logic [1:0]  FN_SPARE = 2'd3;
    localparam int          TAIL     = HOLES + 4;
    localparam int          PHASE_N  = 650;

    typedef struct {
        logic [FW-1:0] fn;
        logic [DW-1:0] base;
        logic [DW-1:0] size;
        int unsigned   idle_pct;
    } txn_t;

    typedef struct {
        logic [SW-1:0] status;
        logic [DW-1:0] base;
        logic [LW-1:0] left;
    } grant_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic [FW-1:0] func = ffha_pkg::FN_LOAD;
    logic [DW-1:0] hole_base = '0;
    logic [DW-1:0] length = '0;
    logic          busy;
    logic          done;
    logic [SW-1:0] status;
    logic [DW-1:0] alloc_base;
    logic [LW-1:0] holes_left;

    txn_t   pend_q[$];
    grant_t grant_q[$];

    // predictor copy of the hole table
    logic [DW-1:0] tbl_base [HOLES];
    logic [DW-1:0] tbl_len  [HOLES];
    bit            tbl_live [HOLES];
    int unsigned   next_slot = 0;
    bit            stuck = 1'b0;

    int unsigned n_sent = 0;
    int unsigned n_queued = 0;
    int unsigned n_errors = 0;
    int unsigned n_results = 0;
    int unsigned n_alloc = 0;
    int unsigned n_nofit = 0;
    int unsigned n_full = 0;
    int unsigned n_halt = 0;

    first_fit_hole_allocator_top #(
        .MAX_HOLES(HOLES),
        .ADDR_BITS(DW)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .hole_base(hole_base),
        .length(length),
        .done(done),
        .status(status),
        .alloc_base(alloc_base),
        .holes_left(holes_left)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic grant_t first_fit(logic [FW-1:0] fn, logic [DW-1:0] b,
                                         logic [DW-1:0] n);
        grant_t r;
        bit     hit;
        int     i;
        r.status = ffha_pkg::STS_DONE;
        r.base   = '0;
        r.left   = '0;
        hit      = 1'b0;
        if (fn == ffha_pkg::FN_LOAD)
        begin
            if (next_slot >= HOLES)
            begin
                r.status = ffha_pkg::STS_FULL;
            end
            else
            begin
                tbl_base[next_slot] = b;
                tbl_len[next_slot]  = n;
                tbl_live[next_slot] = 1'b1;
                next_slot++;
            end
        end
        else if (fn == ffha_pkg::FN_ALLOC)
        begin
            if (stuck)
            begin
                r.status = ffha_pkg::STS_HALT;
            end
            else
            begin
                for (i = 0; i < HOLES; i++)
                begin
                    if (!hit && tbl_live[i] && n <= tbl_len[i])
                    begin
                        hit         = 1'b1;
                        r.base      = tbl_base[i];
                        tbl_base[i] = tbl_base[i] + n;
                        tbl_len[i]  = tbl_len[i] - n;
                        if (tbl_len[i] == '0)
                            tbl_live[i] = 1'b0;
                    end
                end
                if (hit)
                begin
                    r.status = ffha_pkg::STS_ALLOC;
                end
                else
                begin
                    r.status = ffha_pkg::STS_NOFIT;
                    stuck    = 1'b1;
                end
            end
        end
        else if (fn == ffha_pkg::FN_CLEAR)
        begin
            for (i = 0; i < HOLES; i++)
                tbl_live[i] = 1'b0;
            next_slot = 0;
            stuck     = 1'b0;
        end
        for (i = 0; i < HOLES; i++)
            if (tbl_live[i])
                r.left++;
        return r;
    endfunction

    // driver: a transaction is taken at an edge with start high and busy low
    always @(posedge clk)
    begin : drive
        bit   hold;
        txn_t nx;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            hold = start;
            if (start && !busy)
            begin
                grant_q.push_back(first_fit(func, hole_base, length));
                n_sent++;
                hold = 1'b0;
            end
            if (!hold)
            begin
                if (pend_q.size() > 0 && $urandom_range(0, 99) >= pend_q[0].idle_pct)
                begin
                    nx = pend_q.pop_front();
                    func      <= nx.fn;
                    hole_base <= nx.base;
                    length    <= nx.size;
                    start     <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobe is matched against the oldest prediction
    always @(posedge clk)
    begin : watch
        grant_t e;
        if (rst_n && done)
        begin
            n_results++;
            if (grant_q.size() == 0)
            begin
                $error("result with nothing outstanding: status %0d base %h left %0d",
                       status, alloc_base, holes_left);
                n_errors++;
            end
            else
            begin
                e = grant_q.pop_front();
                if (status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, status);
                    n_errors++;
                end
                if (alloc_base !== e.base)
                begin
                    $error("alloc_base: expected %h, got %h", e.base, alloc_base);
                    n_errors++;
                end
                if (holes_left !== e.left)
                begin
                    $error("holes_left: expected %0d, got %0d", e.left, holes_left);
                    n_errors++;
                end
                case (e.status)
                    ffha_pkg::STS_ALLOC: n_alloc++;
                    ffha_pkg::STS_NOFIT: n_nofit++;
                    ffha_pkg::STS_FULL:  n_full++;
                    ffha_pkg::STS_HALT:  n_halt++;
                    default: ;
                endcase
            end
        end
    end

    task automatic push_txn(logic [FW-1:0] fn, logic [DW-1:0] b,
                            logic [DW-1:0] n, int unsigned pct);
        pend_q.push_back('{fn, b, n, pct});
        if (fn != FN_SPARE)
            n_queued++;
    endtask

    function automatic logic [DW-1:0] rand_word();
        return DW'($urandom_range(0, 65535));
    endfunction

    function automatic logic [DW-1:0] pick_hole_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 5)
            return '0;
        if (p < 50)
            return DW'($urandom_range(1, 255));
        return rand_word();
    endfunction

    function automatic logic [DW-1:0] pick_request();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 5)
            return '0;
        if (p < 75)
            return DW'($urandom_range(1, 64));
        if (p < 90)
            return DW'($urandom_range(1, 4096));
        return rand_word();
    endfunction

    // one session: usually a clear, a burst of loads, then mostly allocations
    task automatic add_session(int unsigned pct);
        int unsigned n_load;
        int unsigned n_ops;
        int unsigned p;
        int unsigned k;
        if ($urandom_range(0, 9) != 0)
            push_txn(ffha_pkg::FN_CLEAR, rand_word(), rand_word(), pct);
        n_load = $urandom_range(1, 18);
        for (k = 0; k < n_load; k++)
            push_txn(ffha_pkg::FN_LOAD, rand_word(), pick_hole_len(), pct);
        n_ops = $urandom_range(4, 30);
        for (k = 0; k < n_ops; k++)
        begin
            p = $urandom_range(0, 99);
            if (p < 72)
                push_txn(ffha_pkg::FN_ALLOC, rand_word(), pick_request(), pct);
            else if (p < 88)
                push_txn(ffha_pkg::FN_LOAD, rand_word(), pick_hole_len(), pct);
            else if (p < 93)
                push_txn(FN_SPARE, rand_word(), rand_word(), pct);
            else if (p < 96)
                push_txn(ffha_pkg::FN_CLEAR, rand_word(), rand_word(), pct);
            else
                push_txn(ffha_pkg::FN_ALLOC, rand_word(), rand_word(), pct);
        end
    endtask

    initial
    begin : stimulus
        int unsigned k;
        int unsigned goal;
        for (k = 0; k < HOLES; k++)
            tbl_live[k] = 1'b0;

        // directed: empty table, halt, unused code, full table, wrap, deep scan
        push_txn(ffha_pkg::FN_ALLOC, 16'h0000, 16'h0001, 23);
        push_txn(ffha_pkg::FN_ALLOC, 16'h0000, 16'h0000, 23);
        push_txn(FN_SPARE, 16'hffff, 16'hffff, 23);
        push_txn(ffha_pkg::FN_CLEAR, 16'h0000, 16'h0000, 23);
        push_txn(ffha_pkg::FN_LOAD, 16'h0000, 16'h0000, 23);
        push_txn(ffha_pkg::FN_LOAD, 16'hffff, 16'hffff, 23);
        for (k = 2; k < HOLES - 1; k++)
            push_txn(ffha_pkg::FN_LOAD, rand_word(), DW'($urandom_range(1, 255)), 23);
        push_txn(ffha_pkg::FN_LOAD, 16'h1234, 16'hf000, 23);
        push_txn(ffha_pkg::FN_LOAD, 16'h5555, 16'h0010, 23);
        push_txn(ffha_pkg::FN_ALLOC, 16'h0000, 16'h0000, 23);
        push_txn(ffha_pkg::FN_ALLOC, 16'h0000, 16'h0030, 23);
        push_txn(ffha_pkg::FN_ALLOC, 16'h0000, 16'hffcf, 23);
        push_txn(ffha_pkg::FN_ALLOC, 16'h0000, 16'h8000, 23);
        push_txn(ffha_pkg::FN_ALLOC, 16'h0000, 16'hffff, 23);

        goal = n_queued + PHASE_N;
        while (n_queued < goal)
            add_session(23);
        goal = n_queued + PHASE_N;
        while (n_queued < goal)
            add_session(66);
        goal = n_queued + PHASE_N;
        while (n_queued < goal)
            add_session(0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pend_q.size() != 0 || start || grant_q.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);

        $display("sent %0d transactions, %0d results checked", n_sent, n_results);
        $display("allocated %0d, no fit %0d, table full %0d, refused while halted %0d",
                 n_alloc, n_nofit, n_full, n_halt);
        if (n_errors == 0 && grant_q.size() == 0)
            $display("first_fit_hole_allocator_top: match");
        else
            $display("first_fit_hole_allocator_top: mismatch");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("first_fit_hole_allocator_top: mismatch");
        $finish;
    end

endmodule
